### src/assert_macros.svh
// Assertion macros for the pulse frequency meter checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfm assertion failed");

// Next-cycle implication, never disabled.
`define PFM_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pfm assertion failed");

`endif

### src/pfm_pkg.sv
// ----------------------------------------------------------------------------
// pfm_pkg
// Payload types and fixed widths of the pulse frequency meter.
// ----------------------------------------------------------------------------
package pfm_pkg;

   // Request: pulse edge or measurement query
   localparam logic MODE_PULSE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] time_us;
   } req_type;

   typedef struct packed {
      logic [31:0] frequency_hz_q16;
      logic [48:0] distance_in_q16;
      logic [31:0] speed_mph_q16;
      logic [31:0] pulse_total;
   } rsp_type;

endpackage

### src/pulse_frequency_meter_unit.sv
// ----------------------------------------------------------------------------
// pulse_frequency_meter_unit
// Ring of recent pulse times with a windowed frequency, speed and distance
// measurement on query.
// ----------------------------------------------------------------------------
// A pulse transfer is stored in the ring and gives no response. A query
// transfer walks the timestamp ring back from the newest entry, reading each
// entry through the single synchronous memory read port, passes the setup
// states S_PREP1 and S_PREP2, runs two parallel bit-serial restoring dividers
// (frequency, speed) and then loads the response register. The distance is
// kept up to date on every pulse as a quotient and remainder by 225, so it
// needs no divider. A new request is taken as soon as the unit is idle, also
// while a response still waits in the output register. The ring reads as
// zero after reset through a valid bit per entry.
module pulse_frequency_meter_unit #(
   parameter int RING_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfm_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);
   import pfm_pkg::*;

   localparam int IW    = $clog2(RING_DEPTH);
   localparam int PW    = $clog2(RING_DEPTH) + 1;
   localparam int Q_W   = 57;
   localparam int DEN_W = 44;
   localparam int REM_W = DEN_W + 1;
   localparam int CNT_W = 6;

   // Distance step per pulse: 263*65536 = 225*76604 + 68
   localparam int DIST_STEP_Q = 76604;
   localparam int DIST_STEP_R = 68;
   localparam int DIST_DIV    = 225;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_PREP1 = 3'd3;
   localparam logic [2:0] S_PREP2 = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   localparam logic [IW-1:0] LAST_SLOT = IW'(RING_DEPTH - 1);

   // One restoring division step: returns {remainder, quotient}
   function automatic logic [REM_W+Q_W-1:0] div_step(
      input logic [REM_W-1:0] rem,
      input logic [Q_W-1:0]   quo,
      input logic [DEN_W-1:0] den
   );
      logic [REM_W-1:0] r;
      logic             qb;
      r  = {rem[REM_W-2:0], quo[Q_W-1]};
      qb = (r >= {1'b0, den});
      if (qb) begin
         r = r - {1'b0, den};
      end
      return {r, quo[Q_W-2:0], qb};
   endfunction

   // State
   logic [2:0]       state_ff, state_in;
   logic [31:0]      window_ff;
   logic [IW-1:0]    wslot_ff;
   logic [31:0]      count_ff;
   logic [48:0]      dist_ff;
   logic [7:0]       dist_rem_ff;
   logic [RING_DEPTH-1:0] vld_ff;
   logic [31:0]      mem [RING_DEPTH];
   logic [31:0]      rd_ff;
   logic             rv_ff;

   // Walk
   logic [IW-1:0]    idx_ff;
   logic [PW-1:0]    passed_ff;
   logic [31:0]      now_ff, newest_ff, oldest_ff;

   // Arithmetic
   logic             zero_ff;
   logic [Q_W-1:0]   qf_ff, qs_ff;
   logic [REM_W-1:0] rf_ff, rs_ff;
   logic [DEN_W-1:0] den_s_ff, den_f_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             req_xfer, rsp_xfer;
   logic [31:0]      t_rd;
   logic [PW-1:0]    n_cnt;
   logic [27:0]      n_mega;
   logic [31:0]      span;
   logic [8:0]       dist_sum;
   logic             dist_carry;
   logic [REM_W+Q_W-1:0] sf, ss;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign t_rd   = rv_ff ? rd_ff : 32'd0;
   assign n_cnt  = passed_ff - PW'(1);
   assign n_mega = 28'(n_cnt) * 28'd1000000;
   assign span   = newest_ff - oldest_ff;

   assign dist_sum   = {1'b0, dist_rem_ff} + 9'(DIST_STEP_R);
   assign dist_carry = (dist_sum >= 9'(DIST_DIV));

   assign sf = div_step(rf_ff, qf_ff, den_f_ff);
   assign ss = div_step(rs_ff, qs_ff, den_s_ff);

   // Timestamp ring and its synchronous read port
   always_ff @(posedge clock) begin
      if (req_xfer && req_data.mode == MODE_PULSE) begin
         mem[wslot_ff] <= req_data.time_us;
      end
      rd_ff <= mem[idx_ff];
   end

   // Valid bits, write slot, counter, distance, window register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         wslot_ff    <= '0;
         count_ff    <= '0;
         dist_ff     <= '0;
         dist_rem_ff <= '0;
         window_ff   <= 32'd1000000;
         rv_ff       <= 1'b0;
      end else begin
         rv_ff <= vld_ff[idx_ff];
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
         if (req_xfer && req_data.mode == MODE_PULSE) begin
            vld_ff[wslot_ff] <= 1'b1;
            wslot_ff <= (wslot_ff == LAST_SLOT) ? '0 : wslot_ff + IW'(1);
            count_ff <= count_ff + 32'd1;
            // Counter wraps to zero, distance restarts with it
            if (count_ff == '1) begin
               dist_ff     <= '0;
               dist_rem_ff <= '0;
            end else begin
               dist_ff     <= dist_ff + 49'(DIST_STEP_Q) + 49'(dist_carry);
               dist_rem_ff <= dist_carry ? 8'(dist_sum - 9'(DIST_DIV)) : dist_sum[7:0];
            end
         end
      end
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_data.mode == MODE_QUERY) begin
               state_in = S_READ;
            end
         end
         S_READ:  state_in = (idx_ff == wslot_ff) ? S_PREP1 : S_EVAL;
         S_EVAL: begin
            if (t_rd == 32'd0 || (now_ff - t_rd) > window_ff) begin
               state_in = S_PREP1;
            end else begin
               state_in = S_READ;
            end
         end
         S_PREP1: state_in = S_PREP2;
         S_PREP2: state_in = S_DIV;
         S_DIV:   state_in = (cnt_ff == '0) ? S_OUT : S_DIV;
         S_OUT:   state_in = (!rsp_valid_ff || rsp_ready) ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Walk, setup and divider datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            now_ff    <= req_data.time_us;
            passed_ff <= '0;
            idx_ff    <= (wslot_ff == '0) ? LAST_SLOT : wslot_ff - IW'(1);
         end
         S_EVAL: begin
            if (!(t_rd == 32'd0 || (now_ff - t_rd) > window_ff)) begin
               if (passed_ff == '0) begin
                  newest_ff <= t_rd;
               end
               oldest_ff <= t_rd;
               passed_ff <= passed_ff + PW'(1);
               idx_ff    <= (idx_ff == '0) ? LAST_SLOT : idx_ff - IW'(1);
            end
         end
         S_PREP1: begin
            zero_ff  <= (passed_ff < PW'(2)) || (span == 32'd0);
            qf_ff    <= Q_W'({n_mega, 16'd0});
            den_f_ff <= DEN_W'(span);
            den_s_ff <= DEN_W'(span) * DEN_W'(1503);
         end
         S_PREP2: begin
            qs_ff  <= Q_W'(qf_ff * Q_W'(100));
            rf_ff  <= '0;
            rs_ff  <= '0;
            cnt_ff <= CNT_W'(Q_W - 1);
         end
         S_DIV: begin
            {rf_ff, qf_ff} <= sf;
            {rs_ff, qs_ff} <= ss;
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_ff.pulse_total     <= count_ff;
               rsp_ff.distance_in_q16 <= dist_ff;
               if (zero_ff) begin
                  rsp_ff.frequency_hz_q16 <= '0;
                  rsp_ff.speed_mph_q16    <= '0;
               end else begin
                  rsp_ff.frequency_hz_q16 <= (qf_ff[Q_W-1:32] != '0) ? '1 : qf_ff[31:0];
                  rsp_ff.speed_mph_q16    <= (qs_ff[Q_W-1:32] != '0) ? '1 : qs_ff[31:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### src/pfm_checker.sv
// ----------------------------------------------------------------------------
// pfm_checker
// Port-level checks on the response channel of the pulse frequency meter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfm_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pfm_pkg::rsp_type rsp_data
);
   import pfm_pkg::*;

   // Response register comes up empty
   `PFM_ASSERT_NEXT(a_rst_empty, clock, reset, !rsp_valid)

   // A stalled response transfer holds its payload
   `PFM_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Speed is frequency scaled down, so zero frequency means zero speed
   `PFM_ASSERT_IMP(a_speed_zero, clock, reset, rsp_valid && rsp_data.frequency_hz_q16 == 32'd0, rsp_data.speed_mph_q16 == 32'd0)

   // Speed never exceeds frequency
   `PFM_ASSERT_IMP(a_speed_le, clock, reset, rsp_valid, rsp_data.speed_mph_q16 <= rsp_data.frequency_hz_q16)

endmodule

bind pulse_frequency_meter_unit pfm_checker u_pfm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse frequency meter: a driver and a monitor
// run as clocked blocks, and a behavioural predictor works out the expected
// measurement for each accepted query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import pfm_pkg::*;

   localparam int DEPTH     = 16;
   localparam int LATENCY   = 2 * DEPTH + 80;
   localparam int WDOG_MAX  = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   pulse_frequency_meter_unit #(.RING_DEPTH(DEPTH)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Meter model state
   logic [31:0] ring_times [DEPTH];
   int unsigned ring_slot;
   logic [31:0] pulse_count;
   logic [31:0] window_us;

   req_type pending_reqs [$];
   rsp_type expected_meas [$];
   int      mismatches;
   int      send_idle_pct;
   int      recv_stall_pct;
   int      hold_off_cycles;
   bit      drain_pause;
   int      wdog;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      mismatches++;
   endtask

   function automatic void meter_reset();
      for (int i = 0; i < DEPTH; i++) ring_times[i] = '0;
      ring_slot   = 0;
      pulse_count = '0;
      window_us   = 32'd1000000;
   endfunction

   // Predict a transfer; queries push one expected measurement
   function automatic void measure(input req_type r);
      int unsigned newest, idx, oldest, passed;
      logic [31:0] span;
      logic [63:0] num, freq, speed;
      logic [127:0] dist_full;
      rsp_type m;
      if (r.mode == MODE_PULSE) begin
         ring_times[ring_slot] = r.time_us;
         ring_slot   = (ring_slot + 1) % DEPTH;
         pulse_count = pulse_count + 1;
         return;
      end
      newest = (ring_slot == 0) ? DEPTH - 1 : ring_slot - 1;
      idx    = newest;
      oldest = newest;
      passed = 0;
      for (int i = 0; i < DEPTH; i++) begin
         if (idx == ring_slot) break;
         if (ring_times[idx] == 0 || 32'(r.time_us - ring_times[idx]) > window_us) break;
         oldest = idx;
         passed++;
         idx = (idx == 0) ? DEPTH - 1 : idx - 1;
      end
      freq  = '0;
      speed = '0;
      if (passed >= 2) begin
         span = ring_times[newest] - ring_times[oldest];
         if (span != 0) begin
            num   = 64'd1000000 * 64'(passed - 1) * 64'd65536;
            freq  = num / 64'(span);
            speed = (num * 64'd100) / (64'(span) * 64'd1503);
         end
      end
      dist_full = (128'(pulse_count) * 128'd263 * 128'd65536) / 128'd225;
      m.frequency_hz_q16 = (freq  > 64'hFFFFFFFF) ? 32'hFFFFFFFF : freq[31:0];
      m.speed_mph_q16    = (speed > 64'hFFFFFFFF) ? 32'hFFFFFFFF : speed[31:0];
      m.distance_in_q16  = dist_full[48:0];
      m.pulse_total      = pulse_count;
      expected_meas.push_back(m);
   endfunction

   // Driver: offers queued items, idles at random between transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            measure(req_data);
            void'(pending_reqs.pop_front());
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_reqs.size() > 0 && !drain_pause &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each measurement, stalls at random or for a hold-off
   always @(posedge clock) begin
      rsp_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_meas.size() == 0) begin
               report("unexpected", 64'(rsp_data.pulse_total), 64'd0);
            end else begin
               w = expected_meas.pop_front();
               if (rsp_data.frequency_hz_q16 !== w.frequency_hz_q16)
                  report("frequency", 64'(rsp_data.frequency_hz_q16), 64'(w.frequency_hz_q16));
               if (rsp_data.distance_in_q16 !== w.distance_in_q16)
                  report("distance", 64'(rsp_data.distance_in_q16), 64'(w.distance_in_q16));
               if (rsp_data.speed_mph_q16 !== w.speed_mph_q16)
                  report("speed", 64'(rsp_data.speed_mph_q16), 64'(w.speed_mph_q16));
               if (rsp_data.pulse_total !== w.pulse_total)
                  report("count", 64'(rsp_data.pulse_total), 64'(w.pulse_total));
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || hold_off_cycles > 0)
         wdog <= 0;
      else if (pending_reqs.size() > 0 || expected_meas.size() > 0) begin
         wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) begin
            $display("[pulse_frequency_meter_unit] ERROR");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_meas.size() > 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_window(input logic [31:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      window_us = v;
   endtask

   function automatic req_type mk(input logic m, input logic [31:0] t);
      req_type r;
      r.mode    = m;
      r.time_us = t;
      return r;
   endfunction

   // Train of pulses at a given period plus random jitter from a base time, then a query
   task automatic queue_burst(input int n, input logic [31:0] base, input logic [31:0] period);
      logic [31:0] t;
      t = base;
      for (int i = 0; i < n; i++) begin
         pending_reqs.push_back(mk(MODE_PULSE, t));
         t = t + period + $urandom_range(3);
      end
      pending_reqs.push_back(mk(MODE_QUERY, t + $urandom_range(period)));
   endtask

   // Queues about n items
   task automatic random_phase(input int n);
      int k;
      int b;
      k = 0;
      while (k < n) begin
         if ($urandom_range(9) < 8) begin
            b = $urandom_range(1, 18);
            queue_burst(b, $urandom,
                        ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 20000));
            k += b + 1;
         end else begin
            pending_reqs.push_back(mk($urandom_range(1), $urandom));
            k++;
         end
      end
   endtask

   initial begin
      int n;
      mismatches = 0; send_idle_pct = 0; recv_stall_pct = 0;
      hold_off_cycles = 0; drain_pause = 0; wdog = 0;
      meter_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty ring, extremes, zero time, zero span, full ring wrap
      pending_reqs.push_back(mk(MODE_QUERY, 32'd0));
      pending_reqs.push_back(mk(MODE_PULSE, 32'd0));
      pending_reqs.push_back(mk(MODE_QUERY, 32'd5));
      pending_reqs.push_back(mk(MODE_PULSE, 32'd100));
      pending_reqs.push_back(mk(MODE_PULSE, 32'd100));
      pending_reqs.push_back(mk(MODE_QUERY, 32'd200));
      pending_reqs.push_back(mk(MODE_PULSE, 32'd101));
      pending_reqs.push_back(mk(MODE_QUERY, 32'hFFFFFFFF));
      pending_reqs.push_back(mk(MODE_PULSE, 32'hFFFFFFFF));
      pending_reqs.push_back(mk(MODE_PULSE, 32'h00000001));
      pending_reqs.push_back(mk(MODE_QUERY, 32'h00000002));
      for (int i = 0; i < 17; i++)
         pending_reqs.push_back(mk(MODE_PULSE, 32'h1000 + 32'(i)));
      pending_reqs.push_back(mk(MODE_QUERY, 32'h2000));
      wait_idle();

      // Window at zero: only entries equal to the query time count
      write_window(32'd0);
      queue_burst(5, 32'h5000, 32'd0);
      random_phase(60);
      wait_idle();

      // Window at maximum, receiver held off while sender keeps offering
      write_window(32'hFFFFFFFF);
      send_idle_pct = 0; recv_stall_pct = 58;
      hold_off_cycles = 3000;
      random_phase(160);
      wait_idle();

      // Reset value again, sender paused until all measurements drained
      write_window(32'd1000000);
      send_idle_pct = 58; recv_stall_pct = 0;
      random_phase(80);
      drain_pause = 1;
      while (expected_meas.size() > 0 || req_valid) @(posedge clock);
      drain_pause = 0;
      random_phase(80);
      wait_idle();

      // Random windows, receiver stalling in odd passes, both sides idling in the last
      for (int p = 0; p < 4; p++) begin
         write_window((p % 2) ? $urandom : $urandom_range(1, 50000));
         send_idle_pct  = (p == 3) ? 30 : 0;
         recv_stall_pct = (p == 3) ? 30 : 58 * (p % 2);
         n = 80;
         random_phase(n);
         wait_idle();
      end

      if (mismatches == 0)
         $display("[pulse_frequency_meter_unit] OK");
      else
         $display("[pulse_frequency_meter_unit] ERROR");
      $finish;
   end

endmodule
